// ===== sv/pps_pkg.sv =====
// Shared types, constants and helpers for the preemptive priority scheduler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pps_pkg;

	localparam int MAX_TASKS = 16;
	localparam int SLOT_W    = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int TIME_W    = 16;
	localparam int PRIO_W    = 8;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [3:0]        slot;
		logic [15:0]       task_id;
		logic [15:0]       arrival_tick;
		logic [15:0]       burst_len;
		logic [7:0]        priority_req;
	} req_t;

	typedef struct packed {
		logic              idle;
		logic [3:0]        running_slot;
		logic [15:0]       running_id;
		logic              finished;
		logic [15:0]       finish_tick;
		logic [15:0]       turnaround;
		logic [15:0]       wait_len;
		logic              all_finished;
		logic [15:0]       current_time;
	} rsp_t;

	// one row of the task table
	typedef struct packed {
		logic [TIME_W-1:0] id;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [PRIO_W-1:0] prio;
	} row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_UPDATE,
		ST_REPORT
	} state_t;

	function automatic logic [TIME_W-1:0] time_inc(input logic [TIME_W-1:0] t);
		time_inc = (t == TIME_MAX) ? t : t + TIME_W'(1);
	endfunction

endpackage

// ===== sv/pps_task_table.sv =====
// Task table: one row per slot, single write port, one registered read port.
// Depends on pps_pkg for the row type and depth.
`timescale 1ns / 1ps

module pps_task_table
	import pps_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  row_t              wdata,
	input  logic [SLOT_W-1:0] raddr,
	output row_t              rdata
);

	row_t mem [MAX_TASKS];
	row_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/preemptive_priority_scheduler_core.sv =====
// Preemptive priority scheduler core: FSM, table scan and result register.
// Depends on pps_pkg and pps_task_table.
`timescale 1ns / 1ps

// A load item writes one slot and clears the time; it then passes through the report
// state, and its result is registered onto rsp with done. A tick item with no work
// left takes the same path. Any other tick walks the task table one slot per cycle
// through the table's single read port, then goes through the last, update and report
// states before its result is registered; busy drops in the cycle that done rises.
// A new item is taken only in idle, never while one is in flight. Every result is held on rsp
// for exactly one cycle with done high and must be captured then; the core cannot be
// stalled. process_count may only be written while busy is low.

module preemptive_priority_scheduler_core
	import pps_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  req_t            req,
	input  logic            cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic            done,
	output rsp_t            rsp
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]     count_q;
	logic [TIME_W-1:0]    time_q;
	logic [MAX_TASKS-1:0] busy_slot_q;   // remaining time nonzero
	logic [SLOT_W-1:0]    idx_q;
	logic                 rd_vld_s1;
	logic [SLOT_W-1:0]    rd_idx_s1;
	logic                 found_q;
	logic [SLOT_W-1:0]    pick_q;
	row_t                 best_q;
	logic                 served_q;
	logic                 fin_q;
	logic [TIME_W-1:0]    ta_q;
	logic                 done_q;
	rsp_t                 rsp_q, rsp_d;

	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_waddr;
	row_t                 mem_wdata;
	row_t                 rdata;

	logic [CNT_W-1:0]     n_eff;
	logic [CNT_W-1:0]     n_m1;
	logic [SLOT_W-1:0]    last_idx;
	logic [MAX_TASKS-1:0] count_mask;
	logic                 none_left;
	logic                 accept;
	logic                 cand;
	logic [TIME_W-1:0]    rem_dec;
	logic [TIME_W-1:0]    time_nx;
	logic [TIME_W-1:0]    wt;

	assign n_eff    = (count_q > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : count_q;
	assign n_m1     = n_eff - CNT_W'(1);
	assign last_idx = n_m1[SLOT_W-1:0];

	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			count_mask[i] = (CNT_W'(i) < n_eff);
		end
	end

	assign none_left = ~|(busy_slot_q & count_mask);
	assign accept    = start && (state_q == ST_IDLE);

	// scan compare on the entry read last cycle
	assign cand = rd_vld_s1 && busy_slot_q[rd_idx_s1] && (rdata.arrival <= time_q)
		&& (!found_q || (rdata.prio < best_q.prio));

	assign rem_dec = best_q.remaining - TIME_W'(1);
	assign time_nx = time_inc(time_q);
	assign wt      = (ta_q >= best_q.burst) ? ta_q - best_q.burst : '0;

	pps_task_table u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = (state_q != ST_IDLE);
		mem_we    = 1'b0;
		mem_waddr = req.slot;
		mem_wdata = '{id: req.task_id, arrival: req.arrival_tick, burst: req.burst_len,
			remaining: req.burst_len, prio: req.priority_req};
		rsp_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req.req_type == REQ_LOAD) begin
						mem_we  = 1'b1;
						state_d = ST_REPORT;
					end else if (none_left) begin
						state_d = ST_REPORT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == last_idx) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				mem_we    = found_q;
				mem_waddr = pick_q;
				mem_wdata = best_q;
				mem_wdata.remaining = rem_dec;
				state_d   = ST_REPORT;
			end
			ST_REPORT: begin
				rsp_d.idle         = !served_q;
				rsp_d.running_slot = served_q ? pick_q : '0;
				rsp_d.running_id   = served_q ? best_q.id : '0;
				rsp_d.finished     = fin_q;
				rsp_d.finish_tick  = fin_q ? time_q : '0;
				rsp_d.turnaround   = fin_q ? ta_q : '0;
				rsp_d.wait_len     = fin_q ? wt : '0;
				rsp_d.all_finished = none_left;
				rsp_d.current_time = time_q;
				state_d            = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			time_q      <= '0;
			busy_slot_q <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			found_q     <= 1'b0;
			served_q    <= 1'b0;
			fin_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			rd_idx_s1 <= idx_q;
			done_q    <= (state_q == ST_REPORT);

			if (accept) begin
				idx_q    <= '0;
				found_q  <= 1'b0;
				served_q <= 1'b0;
				fin_q    <= 1'b0;
				if (req.req_type == REQ_LOAD) begin
					busy_slot_q[req.slot] <= (req.burst_len != '0);
					time_q                <= '0;
				end
			end

			if (state_q == ST_SCAN && idx_q != last_idx) begin
				idx_q <= idx_q + SLOT_W'(1);
			end

			if (cand) begin
				found_q <= 1'b1;
			end

			if (state_q == ST_UPDATE) begin
				time_q <= time_nx;
				if (found_q) begin
					busy_slot_q[pick_q] <= (rem_dec != '0);
					served_q            <= 1'b1;
					fin_q               <= (rem_dec == '0);
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cand) begin
			pick_q <= rd_idx_s1;
			best_q <= rdata;
		end
		if (state_q == ST_UPDATE) begin
			ta_q <= (time_nx >= best_q.arrival) ? time_nx - best_q.arrival : '0;
		end
		if (state_q == ST_REPORT) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the core busy");

	a_done_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while core still busy");

	a_finish_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.finished |-> !rsp.idle && rsp.finish_tick == rsp.current_time)
		else $error("finished task reported without a served slot");

	a_load_clears_time: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == REQ_LOAD |=> ##1 done && rsp.current_time == '0)
		else $error("load transfer did not clear the time counter");

endmodule
